// ===== hw/rtl/vln_pkg.sv =====
package vln_pkg;

  localparam int LANES      = 4;
  localparam int COMP_W     = 16;
  localparam int SQ_W       = 31;
  localparam int SUM_W      = 33;
  localparam int TOL_W      = 20;
  localparam int MAG_W      = 17;

  // Per-lane scaling: restoring search for u = floor(c * 2^14 / sqrt(S)).
  localparam int NORM_STEPS = 15;
  localparam int ND_W       = 59;
  localparam int NQ_W       = 47;
  localparam int NT_W       = 64;
  localparam int NR_W       = 61;

  // Length: restoring square root of S.
  localparam int MAG_STEPS  = 17;
  localparam int MD_W       = 33;
  localparam int MT_W       = 35;

  // Register stages from input transfer to the output register.
  localparam int PIPE_DEPTH = 21;
  // Pass decision is made at stage 3 and held until stage 20.
  localparam int PASS_LEN   = PIPE_DEPTH - 3;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 88;

  localparam logic [SUM_W-1:0] ONE_SQ    = SUM_W'(64'd1 << 28);
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(2684);

  localparam logic signed [COMP_W:0]   UNIT_MAX_WIDE = 17'sd32767;
  localparam logic signed [COMP_W-1:0] UNIT_MAX      = 16'sh7FFF;

  typedef logic signed [COMP_W-1:0] comp_t;

  typedef struct packed {
    comp_t unit;
    comp_t raw;
  } lane_out_t;

endpackage

// ===== hw/rtl/vln_isqrt.sv =====
module vln_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vln_pkg::SUM_W-1:0]   sum,
  output logic [vln_pkg::MAG_W-1:0]   mag
);

  localparam int STEPS = vln_pkg::MAG_STEPS;
  localparam int MD_W  = vln_pkg::MD_W;
  localparam int MT_W  = vln_pkg::MT_W;
  localparam int R_W   = vln_pkg::MAG_W;

  // Each stage holds the remainder S - r*r and the partial root r.
  logic [MD_W-1:0] d_st  [STEPS];
  logic [R_W-1:0]  r_st  [STEPS];
  logic [MD_W-1:0] d_nx  [STEPS];
  logic [R_W-1:0]  r_nx  [STEPS];

  always_comb begin
    logic [MD_W-1:0] d_in;
    logic [R_W-1:0]  r_in;
    logic [MT_W-1:0] t;
    int              b;
    for (int k = 0; k < STEPS; k++) begin
      b = STEPS - 1 - k;
      if (k == 0) begin
        d_in = sum;
        r_in = '0;
      end else begin
        d_in = d_st[k-1];
        r_in = r_st[k-1];
      end
      t = (MT_W'(r_in) << (b + 1)) + (MT_W'(1) << (2 * b));
      if (t <= MT_W'(d_in)) begin
        d_nx[k] = d_in - t[MD_W-1:0];
        r_nx[k] = r_in | (R_W'(1) << b);
      end else begin
        d_nx[k] = d_in;
        r_nx[k] = r_in;
      end
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  logic round_up;
  assign round_up = d_st[STEPS-1] > MD_W'(r_st[STEPS-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < STEPS; k++) begin
        d_st[k] <= d_nx[k];
        r_st[k] <= r_nx[k];
      end
      mag <= r_st[STEPS-1] + R_W'(round_up);
    end
  end

endmodule

// ===== hw/rtl/vln_lane.sv =====
module vln_lane (
  input  logic                       clk,
  input  logic                       en,
  input  vln_pkg::comp_t             comp,
  input  logic [vln_pkg::SUM_W-1:0]  sum,
  output logic [vln_pkg::SQ_W-1:0]   sq,
  output vln_pkg::lane_out_t         result
);

  localparam int STEPS = vln_pkg::NORM_STEPS;
  localparam int CW    = vln_pkg::COMP_W;
  localparam int SQ_W  = vln_pkg::SQ_W;
  localparam int SUM_W = vln_pkg::SUM_W;
  localparam int ND_W  = vln_pkg::ND_W;
  localparam int NQ_W  = vln_pkg::NQ_W;
  localparam int NT_W  = vln_pkg::NT_W;
  localparam int NR_W  = vln_pkg::NR_W;
  localparam int U_W   = STEPS;

  logic [CW-1:0]      a;
  logic [2*CW-1:0]    prod;
  vln_pkg::comp_t     c1, c2;
  logic [SQ_W-1:0]    sq1, sq2;

  assign a    = comp[CW-1] ? (~comp + CW'(1)) : comp;
  assign prod = a * a;
  assign sq   = sq1;

  // Stage k holds D = c*c*2^28 - u*u*S, Q = u*S and the partial quotient u.
  logic [ND_W-1:0]  d_st [STEPS];
  logic [NQ_W-1:0]  q_st [STEPS];
  logic [U_W-1:0]   u_st [STEPS];
  logic [SUM_W-1:0] s_st [STEPS];
  vln_pkg::comp_t   c_st [STEPS];

  logic [ND_W-1:0]  d_nx [STEPS];
  logic [NQ_W-1:0]  q_nx [STEPS];
  logic [U_W-1:0]   u_nx [STEPS];
  logic [SUM_W-1:0] s_nx [STEPS];
  vln_pkg::comp_t   c_nx [STEPS];

  always_comb begin
    logic [ND_W-1:0]  d_in;
    logic [NQ_W-1:0]  q_in;
    logic [U_W-1:0]   u_in;
    logic [SUM_W-1:0] s_in;
    vln_pkg::comp_t   c_in;
    logic [NT_W-1:0]  t;
    int               b;
    for (int k = 0; k < STEPS; k++) begin
      b = STEPS - 1 - k;
      if (k == 0) begin
        d_in = {sq2, 28'b0};
        q_in = '0;
        u_in = '0;
        s_in = sum;
        c_in = c2;
      end else begin
        d_in = d_st[k-1];
        q_in = q_st[k-1];
        u_in = u_st[k-1];
        s_in = s_st[k-1];
        c_in = c_st[k-1];
      end
      // (u + 2^b)^2 * S - u^2 * S = Q * 2^(b+1) + S * 2^(2b)
      t = (NT_W'(q_in) << (b + 1)) + (NT_W'(s_in) << (2 * b));
      s_nx[k] = s_in;
      c_nx[k] = c_in;
      if (t <= NT_W'(d_in)) begin
        d_nx[k] = d_in - t[ND_W-1:0];
        q_nx[k] = q_in + (NQ_W'(s_in) << b);
        u_nx[k] = u_in | (U_W'(1) << b);
      end else begin
        d_nx[k] = d_in;
        q_nx[k] = q_in;
        u_nx[k] = u_in;
      end
    end
  end

  // Rounding: (2u+1)^2 * S <= 4 * c*c*2^28 reduces to 4Q + S <= 4D.
  // Equality rounds up, which is away from zero once the sign is applied.
  logic round_up;
  assign round_up = (NR_W'({q_st[STEPS-1], 2'b0}) + NR_W'(s_st[STEPS-1]))
                    <= {d_st[STEPS-1], 2'b0};

  logic [CW-1:0]        ur;
  vln_pkg::comp_t       c_r, c_sg;
  logic signed [CW:0]   sv;

  always_ff @(posedge clk) begin
    if (en) begin
      c1  <= comp;
      sq1 <= prod[SQ_W-1:0];
      c2  <= c1;
      sq2 <= sq1;
      for (int k = 0; k < STEPS; k++) begin
        d_st[k] <= d_nx[k];
        q_st[k] <= q_nx[k];
        u_st[k] <= u_nx[k];
        s_st[k] <= s_nx[k];
        c_st[k] <= c_nx[k];
      end
      ur  <= CW'(u_st[STEPS-1]) + CW'(round_up);
      c_r <= c_st[STEPS-1];
      if (c_r[CW-1]) begin
        sv <= -$signed({1'b0, ur});
      end else begin
        sv <= $signed({1'b0, ur});
      end
      c_sg <= c_r;
      if (sv > vln_pkg::UNIT_MAX_WIDE) begin
        result.unit <= vln_pkg::UNIT_MAX;
      end else begin
        result.unit <= sv[CW-1:0];
      end
      result.raw <= c_sg;
    end
  end

endmodule

// ===== hw/rtl/vln_merge.sv =====
module vln_merge (
  input  logic                              clk,
  input  logic                              en,
  input  vln_pkg::lane_out_t                lane_res [vln_pkg::LANES],
  input  logic                              pass,
  input  logic [vln_pkg::MAG_W-1:0]         mag,
  output logic [vln_pkg::OUT_TDATA_W-1:0]   tdata,
  output logic                              tuser
);

  localparam int CW    = vln_pkg::COMP_W;
  localparam int LANES = vln_pkg::LANES;
  localparam int PAD_W = vln_pkg::OUT_TDATA_W - LANES * CW - vln_pkg::MAG_W;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LANES; i++) begin
        tdata[i*CW +: CW] <= pass ? lane_res[i].raw : lane_res[i].unit;
      end
      tdata[LANES*CW +: vln_pkg::MAG_W] <= mag;
      tdata[vln_pkg::OUT_TDATA_W-1 -: PAD_W] <= '0;
      tuser <= pass;
    end
  end

endmodule

// ===== hw/rtl/vec4_length_normalize.sv =====
// Four-component vector length and normalization. One signed Q1.14 vector
// enters per clock and one result leaves per clock while the output is not
// stalled. The restoring square-root search for the length (17 one-bit
// stages) and the per-lane quotient search (15 one-bit stages plus rounding,
// sign and clamp stages) run side by side. The pipeline advances as a whole,
// so a stalled output holds every stage and the input is not ready until the
// output register is taken. When the squared length lies within the
// tolerance of one or of zero the input components are returned unchanged
// and tuser is set; the length is reported either way. The tolerance
// register is written with cfg_we and should only change while no vector
// is in flight.
module vec4_length_normalize (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // comp_x [15:0], comp_y [31:16], comp_z [47:32], comp_w [63:48]
  input  logic [vln_pkg::IN_TDATA_W-1:0]     s_tdata,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // unit_x [15:0], unit_y [31:16], unit_z [47:32], unit_w [63:48],
  // magnitude [80:64], zero fill [87:81]
  output logic [vln_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // passed_through [0]
  output logic                               m_tuser,
  input  logic                               cfg_we,
  input  logic [vln_pkg::TOL_W-1:0]          cfg_wdata
);

  localparam int LANES = vln_pkg::LANES;
  localparam int CW    = vln_pkg::COMP_W;
  localparam int SUM_W = vln_pkg::SUM_W;
  localparam int DEPTH = vln_pkg::PIPE_DEPTH;

  logic                        en;
  logic [DEPTH-1:0]            vld;
  logic [vln_pkg::TOL_W-1:0]   tolerance;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= vln_pkg::TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], s_tvalid};
    end
  end

  logic [vln_pkg::SQ_W-1:0]   sq       [LANES];
  vln_pkg::lane_out_t         lane_res [LANES];
  logic [SUM_W-1:0]           sum;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    vln_lane u_lane (
      .clk    (clk),
      .en     (en),
      .comp   (s_tdata[i*CW +: CW]),
      .sum    (sum),
      .sq     (sq[i]),
      .result (lane_res[i])
    );
  end

  // The squares of the four lanes merge into the squared length here.
  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]) + SUM_W'(sq[3]);
    end
  end

  logic [vln_pkg::MAG_W-1:0] mag;

  vln_isqrt u_isqrt (
    .clk (clk),
    .en  (en),
    .sum (sum),
    .mag (mag)
  );

  logic [SUM_W-1:0]              diff;
  logic                          pass_now;
  logic [vln_pkg::PASS_LEN-1:0]  pass_sr;

  assign diff     = (sum >= vln_pkg::ONE_SQ) ? (sum - vln_pkg::ONE_SQ)
                                             : (vln_pkg::ONE_SQ - sum);
  assign pass_now = (diff <= SUM_W'(tolerance)) || (sum <= SUM_W'(tolerance));

  always_ff @(posedge clk) begin
    if (en) begin
      pass_sr <= {pass_sr[vln_pkg::PASS_LEN-2:0], pass_now};
    end
  end

  vln_merge u_merge (
    .clk      (clk),
    .en       (en),
    .lane_res (lane_res),
    .pass     (pass_sr[vln_pkg::PASS_LEN-1]),
    .mag      (mag),
    .tdata    (m_tdata),
    .tuser    (m_tuser)
  );

  // A stalled result must hold the whole pipeline, input side included.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input accepted while the output is stalled");

  // A normalized component never exceeds one in size.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |->
      $signed(m_tdata[15:0])  <= 16'sd16384 && $signed(m_tdata[15:0])  >= -16'sd16384 &&
      $signed(m_tdata[31:16]) <= 16'sd16384 && $signed(m_tdata[31:16]) >= -16'sd16384 &&
      $signed(m_tdata[47:32]) <= 16'sd16384 && $signed(m_tdata[47:32]) >= -16'sd16384 &&
      $signed(m_tdata[63:48]) <= 16'sd16384 && $signed(m_tdata[63:48]) >= -16'sd16384)
    else $error("normalized component out of unit range");

  // A zero length means a zero vector, which always passes through.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[80:64] == 17'd0) |-> m_tuser)
    else $error("zero length without pass-through");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam int LANES       = vln_pkg::LANES;
  localparam int MAG_W       = vln_pkg::MAG_W;
  localparam int TOL_W       = vln_pkg::TOL_W;
  localparam int IN_TDATA_W  = vln_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = vln_pkg::OUT_TDATA_W;
  localparam int MAG_STEPS   = vln_pkg::MAG_STEPS;
  localparam int NORM_STEPS  = vln_pkg::NORM_STEPS;
  localparam int PIPE_DEPTH  = vln_pkg::PIPE_DEPTH;
  localparam logic [vln_pkg::SUM_W-1:0] ONE_SQ    = vln_pkg::ONE_SQ;
  localparam logic [TOL_W-1:0]          TOL_RESET = vln_pkg::TOL_RESET;

  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_VECTORS  = 230;
  localparam int TOL_PHASES     = 5;

  typedef vln_pkg::comp_t comp_t;
  typedef comp_t [LANES-1:0] vec4_t;

  typedef struct packed {
    vec4_t            unit;
    logic [MAG_W-1:0] mag;
    logic             pass;
  } norm_result_t;

  typedef enum logic {ROW_VECTOR, ROW_TOLERANCE} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    vec4_t            comps;
    logic [TOL_W-1:0] tol;
    bit               known;
    norm_result_t     want;
  } stim_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_BURSTY, RX_COMB} rx_mode_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tuser;
  logic                   cfg_we;
  logic [TOL_W-1:0]       cfg_wdata;

  norm_result_t     norm_pending[$];
  stim_row_t        dir_rows[$];
  logic [TOL_W-1:0] tol_shadow;
  norm_result_t     want_res;
  norm_result_t     got_res;
  rx_mode_t         rx_mode;
  int               rx_cycle;
  int               rx_stall_left;
  int               cycles;
  int               errors;
  int               n_sent;
  int               n_directed;
  int               n_results;
  int               n_passed;
  int               n_tol_writes;
  string            lane_name[LANES] = '{"x", "y", "z", "w"};

  vec4_length_normalize dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = MAG_STEPS - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= s) r = t;
    end
    return r;
  endfunction

  // Nearest integer to c * 2^14 / sqrt(s), found by squaring both sides so
  // that no division or real arithmetic is needed.
  function automatic comp_t scale_component(input comp_t c, input logic [63:0] s);
    longint      cv;
    longint      r;
    logic [63:0] a;
    logic [63:0] num;
    logic [63:0] u;
    logic [63:0] t;
    logic [63:0] h;
    cv  = c;
    a   = (cv < 0) ? -cv : cv;
    num = (a * a) << 28;
    u   = '0;
    for (int b = NORM_STEPS - 1; b >= 0; b--) begin
      t = u | (64'd1 << b);
      if (t * t * s <= num) u = t;
    end
    h = 2 * u + 1;
    if (h * h * s <= (num << 2)) u = u + 1;
    r = (cv < 0) ? -longint'(u) : longint'(u);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return comp_t'(r);
  endfunction

  function automatic norm_result_t normalize_vec4(input vec4_t c);
    norm_result_t res;
    logic [63:0]  sq;
    logic [63:0]  root;
    logic [63:0]  gap;
    longint       cv;
    sq = '0;
    for (int i = 0; i < LANES; i++) begin
      cv = c[i];
      sq = sq + 64'(cv * cv);
    end
    root = floor_sqrt(sq);
    if (sq - root * root > root) root = root + 1;
    gap = (sq >= 64'(ONE_SQ)) ? sq - 64'(ONE_SQ) : 64'(ONE_SQ) - sq;
    res.pass = (gap <= 64'(tol_shadow)) || (sq <= 64'(tol_shadow));
    for (int i = 0; i < LANES; i++)
      res.unit[i] = res.pass ? c[i] : scale_component(c[i], sq);
    res.mag = root[MAG_W-1:0];
    return res;
  endfunction

  function automatic comp_t extreme_component();
    case ($urandom_range(0, 7))
      0: return comp_t'(-32768);
      1: return comp_t'(32767);
      2: return comp_t'(0);
      3: return comp_t'(-1);
      4: return comp_t'(1);
      5: return comp_t'(16384);
      6: return comp_t'(-16384);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic vec4_t random_vec4();
    vec4_t       v;
    logic [63:0] part;
    longint      root;
    int          kind;
    int          k;
    kind = $urandom_range(0, 99);
    v = '0;
    if (kind < 40) begin
      for (int i = 0; i < LANES; i++) v[i] = comp_t'($urandom);
    end else if (kind < 65) begin
      // Near unit length: one lane makes up what the other three leave of one.
      k = $urandom_range(0, LANES - 1);
      part = '0;
      for (int i = 0; i < LANES; i++) begin
        if (i != k) begin
          v[i] = comp_t'(int'($urandom_range(0, 18000)) - 9000);
          part = part + 64'(longint'(v[i]) * longint'(v[i]));
        end
      end
      root = longint'(floor_sqrt((64'd1 << 28) - part)) + int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(0, 1) == 1) root = -root;
      v[k] = comp_t'(root);
    end else if (kind < 80) begin
      for (int i = 0; i < LANES; i++) v[i] = comp_t'(int'($urandom_range(0, 80)) - 40);
    end else if (kind < 92) begin
      for (int i = 0; i < LANES; i++) v[i] = extreme_component();
    end else begin
      v[$urandom_range(0, LANES - 1)] = comp_t'($urandom);
    end
    return v;
  endfunction

  task automatic add_tolerance(input int value);
    stim_row_t row;
    row.kind  = ROW_TOLERANCE;
    row.comps = '0;
    row.tol   = TOL_W'(value);
    row.known = 1'b0;
    row.want  = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_vector(input int x, input int y, input int z, input int w);
    stim_row_t row;
    row.kind     = ROW_VECTOR;
    row.comps[0] = comp_t'(x);
    row.comps[1] = comp_t'(y);
    row.comps[2] = comp_t'(z);
    row.comps[3] = comp_t'(w);
    row.tol      = '0;
    row.known    = 1'b0;
    row.want     = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_known(input int x, input int y, input int z, input int w,
                           input int ux, input int uy, input int uz, input int uw,
                           input int mag, input bit pass);
    stim_row_t row;
    row.kind         = ROW_VECTOR;
    row.comps[0]     = comp_t'(x);
    row.comps[1]     = comp_t'(y);
    row.comps[2]     = comp_t'(z);
    row.comps[3]     = comp_t'(w);
    row.tol          = '0;
    row.known        = 1'b1;
    row.want.unit[0] = comp_t'(ux);
    row.want.unit[1] = comp_t'(uy);
    row.want.unit[2] = comp_t'(uz);
    row.want.unit[3] = comp_t'(uw);
    row.want.mag     = MAG_W'(mag);
    row.want.pass    = pass;
    dir_rows.push_back(row);
  endtask

  task automatic send_vector(input vec4_t c, input bit known, input norm_result_t want);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    norm_pending.push_back(known ? want : normalize_vec4(c));
    n_sent++;
  endtask

  task automatic idle_sender(input int gap);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Stop sending, let every vector in flight come out, then give the
  // pipeline its full depth again before anything else happens.
  task automatic drain_pipeline();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (norm_pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] value);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= value;
    tol_shadow  = value;
    n_tol_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic flag_mismatch(input string field, input longint want, input longint got);
    errors++;
    $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
  endtask

  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 300 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: begin
        m_tready <= 1'b1;
      end
      RX_RANDOM: begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
      RX_BURSTY: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
          rx_stall_left = $urandom_range(1, 16);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
      default: begin
        m_tready <= (rx_cycle % 5 != 0);
      end
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_res.unit = m_tdata[IN_TDATA_W-1:0];
      got_res.mag  = m_tdata[IN_TDATA_W +: MAG_W];
      got_res.pass = m_tuser;
      n_results++;
      if (m_tuser) n_passed++;
      if (norm_pending.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no vector outstanding, magnitude %0d",
                 $time, got_res.mag);
      end else begin
        want_res = norm_pending.pop_front();
        for (int i = 0; i < LANES; i++)
          if (got_res.unit[i] !== want_res.unit[i])
            flag_mismatch({"unit_", lane_name[i]}, $signed(want_res.unit[i]),
                          $signed(got_res.unit[i]));
        if (got_res.mag !== want_res.mag)
          flag_mismatch("magnitude", want_res.mag, got_res.mag);
        if (got_res.pass !== want_res.pass)
          flag_mismatch("passed_through", want_res.pass, got_res.pass);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               norm_pending.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [TOL_W-1:0] tol_plan[TOL_PHASES];
    int               burst_left;

    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    tol_shadow    = TOL_RESET;
    rx_mode       = RX_OPEN;
    rx_cycle      = 0;
    rx_stall_left = 0;
    cycles        = 0;
    errors        = 0;
    n_sent        = 0;
    n_results     = 0;
    n_passed      = 0;
    n_tol_writes  = 0;

    // The first rows rely on the tolerance coming out of reset.
    add_known(0, 0, 0, 0,                   0, 0, 0, 0,                   0, 1'b1);
    add_known(16384, 0, 0, 0,               16384, 0, 0, 0,               16384, 1'b1);
    add_known(0, 0, 0, -16384,              0, 0, 0, -16384,              16384, 1'b1);
    add_known(8192, 8192, 8192, 8192,       8192, 8192, 8192, 8192,       16384, 1'b1);
    add_known(-32768, 0, 0, 0,              -16384, 0, 0, 0,              32768, 1'b0);
    add_known(-32768, -32768, -32768, -32768, -8192, -8192, -8192, -8192, 65536, 1'b0);
    add_known(32767, 32767, 32767, 32767,   8192, 8192, 8192, 8192,       65534, 1'b0);
    add_known(100, 0, 0, 0,                 16384, 0, 0, 0,               100, 1'b0);
    add_known(0, 0, 0, -1,                  0, 0, 0, -1,                  1, 1'b1);
    add_vector(32767, -32768, 1, -1);
    add_vector(3, -4, 0, 0);
    add_vector(-12345, 23456, -1, 777);
    // Just under unit length, on either side of the margin.
    add_tolerance(32767);
    add_known(16383, 0, 0, 0,               16383, 0, 0, 0,               16383, 1'b1);
    add_tolerance(32766);
    add_known(16383, 0, 0, 0,               16384, 0, 0, 0,               16383, 1'b0);
    // Just over unit length and just over zero, on either side of the margin.
    add_tolerance(25);
    add_known(0, 16384, -5, 0,              0, 16384, -5, 0,              16384, 1'b1);
    add_vector(0, 16384, -5, 1);
    add_known(3, 0, 4, 0,                   3, 0, 4, 0,                   5, 1'b1);
    add_vector(3, 0, 4, -1);
    add_tolerance(0);
    add_known(0, 0, 0, 0,                   0, 0, 0, 0,                   0, 1'b1);
    add_known(0, 0, 16384, 0,               0, 0, 16384, 0,               16384, 1'b1);
    add_known(0, -1, 0, 0,                  0, -16384, 0, 0,              1, 1'b0);
    add_tolerance(1048575);
    add_known(0, 0, 0, 1024,                0, 0, 0, 16384,               1024, 1'b0);
    add_known(-1023, 0, 0, 0,               -1023, 0, 0, 0,               1023, 1'b1);
    add_vector(16384, -1000, 100, 7);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_TOLERANCE) begin
        drain_pipeline();
        write_tolerance(dir_rows[r].tol);
      end else begin
        send_vector(dir_rows[r].comps, dir_rows[r].known, dir_rows[r].want);
      end
    end
    n_directed = n_sent;

    tol_plan[0] = TOL_RESET;
    tol_plan[1] = '0;
    tol_plan[2] = '1;
    tol_plan[3] = TOL_W'($urandom_range(0, 1048575));
    tol_plan[4] = TOL_W'($urandom_range(0, 70000));

    for (int p = 0; p < TOL_PHASES; p++) begin
      drain_pipeline();
      write_tolerance(tol_plan[p]);
      burst_left = 0;
      for (int n = 0; n < PHASE_VECTORS; n++) begin
        // Hold the source off once until the pipeline has emptied.
        if (p == 2 && n == PHASE_VECTORS / 2) begin
          drain_pipeline();
          burst_left = 0;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 12));
        end
        send_vector(random_vec4(), 1'b0, '0);
        burst_left--;
      end
    end

    drain_pipeline();

    $display("Sent %0d vectors (%0d directed) under %0d tolerance writes;", n_sent,
             n_directed, n_tol_writes);
    $display("checked %0d results, %0d of them passed through unchanged.", n_results,
             n_passed);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
